FILE: rtl/cdpp_pkg.sv
// ----------------------------------------------------------------------------
// CMCE downlink PDU packer package
// Item and segment types, opcode and status codes, and the per-PDU segment
// tables that drive the bit packer.
// ----------------------------------------------------------------------------
package cdpp_pkg;

    localparam int ACC_W = 32;
    localparam int CNT_W = 5;
    localparam int SEG_VAL_W = 24;
    localparam int SEG_WID_W = 5;
    localparam int SEG_IDX_W = 3;

    localparam logic [3:0] OP_ALERT     = 4'd0;
    localparam logic [3:0] OP_PROCEED   = 4'd1;
    localparam logic [3:0] OP_CONNECT   = 4'd2;
    localparam logic [3:0] OP_CONN_ACK  = 4'd3;
    localparam logic [3:0] OP_RELEASE   = 4'd4;
    localparam logic [3:0] OP_SETUP     = 4'd5;
    localparam logic [3:0] OP_TX_CEASED = 4'd6;
    localparam logic [3:0] OP_TX_GRANT  = 4'd7;
    localparam logic [3:0] OP_SDS_HDR   = 4'd8;
    localparam logic [3:0] OP_SDS_BYTE  = 4'd9;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_LEN = 2'd1;
    localparam logic [1:0] STAT_SEQ     = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [13:0] call_id;
        logic [3:0]  time_out;
        logic [5:0]  flags;
        logic [9:0]  service_info;
        logic [1:0]  grant;
        logic [3:0]  priority_req;
        logic [4:0]  cause;
        logic [23:0] party_ssi;
        logic [7:0]  sds_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [SEG_VAL_W-1:0] val;
        logic [SEG_WID_W-1:0] width;
    } seg_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic pop;
    } pk_ctl_t;

    function automatic logic [4:0] pdu_code(logic [3:0] op);
        logic [4:0] t;
        case (op)
            OP_ALERT:     t = 5'd0;
            OP_PROCEED:   t = 5'd1;
            OP_CONNECT:   t = 5'd2;
            OP_CONN_ACK:  t = 5'd3;
            OP_RELEASE:   t = 5'd6;
            OP_SETUP:     t = 5'd7;
            OP_TX_CEASED: t = 5'd9;
            default:      t = 5'd11;
        endcase
        return t;
    endfunction

    // Number of segments in the current item.
    function automatic logic [SEG_IDX_W-1:0] seg_count(item_t it, logic end_byte);
        logic [SEG_IDX_W-1:0] n;
        case (it.opcode)
            OP_ALERT, OP_PROCEED, OP_CONNECT, OP_CONN_ACK,
            OP_RELEASE, OP_TX_CEASED, OP_TX_GRANT: n = 3'd2;
            OP_SETUP:    n = (it.party_ssi != 24'd0) ? 3'd5 : 3'd3;
            OP_SDS_HDR:  n = 3'd3;
            OP_SDS_BYTE: n = end_byte ? 3'd2 : 3'd1;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    // One segment: a run of up to 24 bits, sent MSB first.
    function automatic seg_t seg_get(item_t it, logic [SEG_IDX_W-1:0] idx);
        seg_t s;
        logic [2:0] mode;
        logic [1:0] sp;
        s.val = '0;
        s.width = '0;
        mode = it.service_info[9:7];
        sp = (mode == 3'd0) ? it.service_info[3:2] : it.service_info[1:0];
        if (it.opcode == OP_SDS_BYTE) begin
            if (idx == 3'd0) begin
                s.val = {16'd0, it.data_byte};
                s.width = 5'd8;
            end
            else begin
                s.width = 5'd1;
            end
        end
        else if (it.opcode == OP_SDS_HDR) begin
            case (idx)
                3'd0: begin
                    s.val = {17'd0, 5'd15, 2'd1};
                    s.width = 5'd7;
                end
                3'd1: begin
                    s.val = it.party_ssi;
                    s.width = 5'd24;
                end
                default: begin
                    // Length indicator in bits, eleven bits wide.
                    s.val = {11'd0, 2'd3, it.sds_length, 3'd0};
                    s.width = 5'd13;
                end
            endcase
        end
        else if (idx == 3'd0) begin
            s.val = {5'd0, pdu_code(it.opcode), it.call_id};
            s.width = 5'd19;
        end
        else begin
            case (it.opcode)
                OP_ALERT: begin
                    s.val = {17'd0, it.time_out[2:0], 1'b1, it.flags[1], 2'b00};
                    s.width = 5'd7;
                end
                OP_PROCEED: begin
                    s.val = {18'd0, it.time_out[2:0], it.flags[0], it.flags[1], 1'b0};
                    s.width = 5'd6;
                end
                OP_CONNECT: begin
                    s.val = {4'd0, it.time_out, it.flags[0], it.flags[1], it.grant,
                             it.flags[2], it.flags[3], 2'b11, it.priority_req, 4'd0};
                    s.width = 5'd20;
                end
                OP_CONN_ACK: begin
                    s.val = {16'd0, it.time_out, it.grant, it.flags[2], 1'b0};
                    s.width = 5'd8;
                end
                OP_RELEASE: begin
                    s.val = {18'd0, it.cause, 1'b0};
                    s.width = 5'd6;
                end
                OP_SETUP: begin
                    case (idx)
                        3'd1: begin
                            s.val = {3'd0, it.time_out, it.flags[0], it.flags[1], mode,
                                     it.service_info[6], it.service_info[5:4], sp,
                                     it.grant, it.flags[2], it.priority_req};
                            s.width = 5'd21;
                        end
                        3'd2: begin
                            // O-bit alone, or o-bit, m-bit and the calling party
                            // element header when an SSI is present.
                            if (it.party_ssi != 24'd0) begin
                                s.val = {18'd0, 6'b100101};
                                s.width = 5'd6;
                            end
                            else begin
                                s.width = 5'd1;
                            end
                        end
                        3'd3: begin
                            s.val = it.party_ssi;
                            s.width = 5'd24;
                        end
                        default: begin
                            s.width = 5'd1;
                        end
                    endcase
                end
                OP_TX_CEASED: begin
                    s.val = {22'd0, it.flags[2], 1'b0};
                    s.width = 5'd2;
                end
                default: begin
                    s.val = {18'd0, it.grant, it.flags[2], it.flags[4], it.flags[5], 1'b0};
                    s.width = 5'd6;
                end
            endcase
        end
        return s;
    endfunction

endpackage

FILE: rtl/cdpp_packer.sv
// ----------------------------------------------------------------------------
// CMCE downlink PDU bit packer
// Shared shift unit: appends one segment per cycle, while load is set, to a
// bit accumulator and hands out the oldest eight bits as a byte.
// ----------------------------------------------------------------------------
module cdpp_packer
    import cdpp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pk_ctl_t          ctl,
    input  seg_t             seg,
    output logic [7:0]       head_byte,
    output logic [CNT_W-1:0] cnt,
    output logic [7:0]       body_bits
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       bits_reg, bits_next;
    logic [ACC_W+7:0] aligned;

    // The oldest pending bit lands in bit 7; missing low bits read as zero.
    assign aligned = {acc_reg, 8'd0} >> cnt_reg;
    assign head_byte = aligned[7:0];
    assign cnt = cnt_reg;
    assign body_bits = bits_reg;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        bits_next = bits_reg;
        if (ctl.clear) begin
            acc_next = '0;
            cnt_next = '0;
            bits_next = '0;
        end
        else if (ctl.load) begin
            acc_next = (acc_reg << seg.width) | ACC_W'(seg.val);
            cnt_next = cnt_reg + CNT_W'(seg.width);
            bits_next = bits_reg + 8'(seg.width);
        end
        else if (ctl.pop) begin
            cnt_next = (cnt_reg >= CNT_W'(8)) ? cnt_reg - CNT_W'(8) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            bits_reg <= '0;
        end
        else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            bits_reg <= bits_next;
        end
    end

endmodule

FILE: rtl/cmce_downlink_pdu_packer_unit.sv
// ----------------------------------------------------------------------------
// CMCE downlink PDU packer unit
// Packs downlink call-control PDU bodies and short data messages into bytes.
// ----------------------------------------------------------------------------
// Usage: one request beat on the s_axis channel selects a PDU type (tuser)
// and carries all possible fields (tdata). The body comes out on m_axis as
// bytes, MSB first; the final byte has tlast set and its tdata carries the
// total body bit count. A short data message is one header beat followed by
// one beat per user byte; bytes stream out as they fill, and the last user
// byte closes the body. Errors give a single beat with tlast set, count zero
// and a nonzero status in tuser.
// Sequencing: after a beat is accepted, the sequencer interleaves segment
// loads (one to five) with output byte extractions (up to nine), which
// share one shift unit, and returns to idle, also when a beat ends without
// a final byte; s_axis_tready is low meanwhile, so a new request is taken
// only once the last one is through. An error beat is sent from its own
// state before the return to idle; an unused opcode is dropped on accept.
// Reset clears all partial bits and any pending short data message. When
// the receiver stalls, the finished byte waits in the output register and
// the sequencer holds before its next byte until the waiting one is taken.
// ----------------------------------------------------------------------------
module cmce_downlink_pdu_packer_unit
    import cdpp_pkg::*;
#(
    parameter int MAX_SDS_BYTES = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // call_id[13:0], time_out[17:14], flags[23:18], service_info[33:24],
    // grant[35:34], priority_req[39:36], cause[44:40], party_ssi[68:45],
    // sds_length[76:69], data_byte[84:77], zero pad[87:85]
    input  logic [87:0] s_axis_tdata,
    // opcode[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], bit_count[15:8]
    output logic [15:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int BL_W = $clog2(MAX_SDS_BYTES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_ERR  = 2'd2;

    logic [1:0]           state_reg, state_next;
    item_t                item_reg, item_next, in_item;
    logic [SEG_IDX_W-1:0] seg_idx_reg, seg_idx_next, nseg;
    logic                 end_reg, end_next;
    logic [BL_W-1:0]      bytes_left_reg, bytes_left_next;
    logic [1:0]           err_reg, err_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic [7:0] out_bits_reg, out_bits_next;
    logic [1:0] out_stat_reg, out_stat_next;

    pk_ctl_t          pk_ctl;
    seg_t             seg;
    logic [7:0]       pk_byte;
    logic [CNT_W-1:0] pk_cnt;
    logic [7:0]       pk_bits;

    logic can_emit, segs_done, closes, have_byte, is_last, accept, len_bad;

    assign in_item = '{
        opcode:       s_axis_tuser,
        call_id:      s_axis_tdata[13:0],
        time_out:     s_axis_tdata[17:14],
        flags:        s_axis_tdata[23:18],
        service_info: s_axis_tdata[33:24],
        grant:        s_axis_tdata[35:34],
        priority_req: s_axis_tdata[39:36],
        cause:        s_axis_tdata[44:40],
        party_ssi:    s_axis_tdata[68:45],
        sds_length:   s_axis_tdata[76:69],
        data_byte:    s_axis_tdata[84:77]
    };

    cdpp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pk_ctl),
        .seg       (seg),
        .head_byte (pk_byte),
        .cnt       (pk_cnt),
        .body_bits (pk_bits)
    );

    assign seg = seg_get(item_reg, seg_idx_reg);
    assign nseg = seg_count(item_reg, end_reg);
    assign segs_done = (seg_idx_reg == nseg);
    // PDUs close at the end of their request; a short data message closes
    // only on its last user byte.
    assign closes = (item_reg.opcode <= OP_TX_GRANT) ||
                    ((item_reg.opcode == OP_SDS_BYTE) && end_reg);
    assign have_byte = (pk_cnt >= CNT_W'(8)) || (segs_done && closes && (pk_cnt != '0));
    assign is_last = segs_done && closes && (pk_cnt <= CNT_W'(8));
    assign can_emit = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign len_bad = (in_item.sds_length == 8'd0) ||
                     (in_item.sds_length > 8'(MAX_SDS_BYTES));

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        seg_idx_next = seg_idx_reg;
        end_next = end_reg;
        bytes_left_next = bytes_left_reg;
        err_next = err_reg;
        pk_ctl = '0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_bits_next = out_bits_reg;
        out_stat_next = out_stat_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_item.opcode <= OP_SDS_HDR) begin
                        pk_ctl.clear = 1'b1;
                        bytes_left_next = '0;
                        item_next = in_item;
                        seg_idx_next = '0;
                        end_next = 1'b0;
                        state_next = S_RUN;
                        if (in_item.opcode == OP_SDS_HDR) begin
                            if (len_bad) begin
                                err_next = STAT_BAD_LEN;
                                state_next = S_ERR;
                            end
                            else begin
                                bytes_left_next = in_item.sds_length[BL_W-1:0];
                            end
                        end
                    end
                    else if (in_item.opcode == OP_SDS_BYTE) begin
                        if (bytes_left_reg == '0) begin
                            err_next = STAT_SEQ;
                            state_next = S_ERR;
                        end
                        else begin
                            bytes_left_next = bytes_left_reg - BL_W'(1);
                            end_next = (bytes_left_reg == BL_W'(1));
                            item_next = in_item;
                            seg_idx_next = '0;
                            state_next = S_RUN;
                        end
                    end
                end
            end
            S_RUN: begin
                if (have_byte) begin
                    if (can_emit) begin
                        out_valid_next = 1'b1;
                        out_byte_next = pk_byte;
                        out_last_next = is_last;
                        out_bits_next = is_last ? pk_bits : 8'd0;
                        out_stat_next = STAT_OK;
                        pk_ctl.pop = 1'b1;
                        if (is_last) begin
                            pk_ctl.clear = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (!segs_done) begin
                    pk_ctl.load = 1'b1;
                    seg_idx_next = seg_idx_reg + SEG_IDX_W'(1);
                end
                else begin
                    state_next = S_IDLE;
                end
            end
            S_ERR: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    out_byte_next = 8'd0;
                    out_last_next = 1'b1;
                    out_bits_next = 8'd0;
                    out_stat_next = err_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            seg_idx_reg <= '0;
            end_reg <= 1'b0;
            bytes_left_reg <= '0;
            err_reg <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            seg_idx_reg <= seg_idx_next;
            end_reg <= end_next;
            bytes_left_reg <= bytes_left_next;
            err_reg <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_bits_reg <= out_bits_next;
        out_stat_reg <= out_stat_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_bits_reg, out_byte_reg};
    assign m_axis_tuser = out_stat_reg;
    assign m_axis_tlast = out_last_reg;

endmodule

FILE: sim/cmce_downlink_pdu_packer_unit_tb.sv
// ----------------------------------------------------------------------------
// CMCE downlink PDU packer unit testbench
// Sends call-control PDU requests and short data messages on the request
// stream and checks every body byte against a bit-level packing predictor.
// Directed extremes come first, then random traffic under several idle and
// backpressure mixes.
// ----------------------------------------------------------------------------
module cmce_downlink_pdu_packer_unit_tb;
    import cdpp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SDS_LEN = 24;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 30;
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [7:0] bit_count;
        logic [1:0] status;
    } body_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [87:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    body_beat_t  body_beats_due[$];
    body_beat_t  step_beats[$];
    body_beat_t  want_beat;

    // Packer state of the predictor.
    logic [7:0]  pk_byte;
    int          pk_cnt;
    int          sds_left;
    logic [7:0]  body_len;

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    cmce_downlink_pdu_packer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task add_beat(input logic [7:0] b, input logic l, input logic [7:0] n,
                  input logic [1:0] st);
        if (step_beats.size() < 9)
            step_beats.push_back('{out_byte: b, last: l, bit_count: n, status: st});
    endtask

    task shift_field(input logic [23:0] v, input int nb);
        for (int i = nb - 1; i >= 0; i--)
        begin
            pk_byte = {pk_byte[6:0], v[i]};
            pk_cnt++;
            body_len++;
            if (pk_cnt == 8)
            begin
                add_beat(pk_byte, 1'b0, 8'd0, STAT_OK);
                pk_byte = '0;
                pk_cnt = 0;
            end
        end
    endtask

    task clear_packer();
        pk_byte = '0;
        pk_cnt = 0;
        sds_left = 0;
        body_len = '0;
    endtask

    task close_body();
        body_beat_t tail;
        if (pk_cnt > 0)
        begin
            add_beat(pk_byte << (8 - pk_cnt), 1'b1, body_len, STAT_OK);
        end
        else if (step_beats.size() > 0)
        begin
            tail = step_beats.pop_back();
            tail.last = 1'b1;
            tail.bit_count = body_len;
            step_beats.push_back(tail);
        end
        clear_packer();
    endtask

    task pack_request(input item_t it);
        logic [2:0] mode;
        logic       hook;
        logic       simplex;
        logic       trp;
        mode = it.service_info[9:7];
        hook = it.flags[0];
        simplex = it.flags[1];
        trp = it.flags[2];
        step_beats.delete();
        if (it.opcode == OP_SDS_BYTE)
        begin
            if (sds_left == 0)
            begin
                add_beat(8'd0, 1'b1, 8'd0, STAT_SEQ);
            end
            else
            begin
                shift_field(it.data_byte, 8);
                sds_left--;
                if (sds_left == 0)
                begin
                    shift_field(0, 1);
                    close_body();
                end
            end
        end
        else if (it.opcode < OP_UNUSED_LO)
        begin
            clear_packer();
            if (it.opcode == OP_SDS_HDR)
            begin
                if (it.sds_length == 0 || it.sds_length > MAX_SDS_LEN)
                begin
                    add_beat(8'd0, 1'b1, 8'd0, STAT_BAD_LEN);
                end
                else
                begin
                    shift_field(15, 5);
                    shift_field(1, 2);
                    shift_field(it.party_ssi, 24);
                    shift_field(3, 2);
                    shift_field({it.sds_length, 3'b000}, 11);
                    sds_left = it.sds_length;
                end
            end
            else
            begin
                case (it.opcode)
                    OP_ALERT: begin
                        shift_field(0, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.time_out[2:0], 3);
                        shift_field(1, 1);
                        shift_field(simplex, 1);
                        shift_field(0, 2);
                    end
                    OP_PROCEED: begin
                        shift_field(1, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.time_out[2:0], 3);
                        shift_field(hook, 1);
                        shift_field(simplex, 1);
                        shift_field(0, 1);
                    end
                    OP_CONNECT: begin
                        shift_field(2, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.time_out, 4);
                        shift_field(hook, 1);
                        shift_field(simplex, 1);
                        shift_field(it.grant, 2);
                        shift_field(trp, 1);
                        shift_field(it.flags[3], 1);
                        shift_field(3, 2);
                        shift_field(it.priority_req, 4);
                        shift_field(0, 4);
                    end
                    OP_CONN_ACK: begin
                        shift_field(3, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.time_out, 4);
                        shift_field(it.grant, 2);
                        shift_field(trp, 1);
                        shift_field(0, 1);
                    end
                    OP_RELEASE: begin
                        shift_field(6, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.cause, 5);
                        shift_field(0, 1);
                    end
                    OP_SETUP: begin
                        shift_field(7, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.time_out, 4);
                        shift_field(hook, 1);
                        shift_field(simplex, 1);
                        // Basic service info: speech service for TCH/S,
                        // slots per frame for any other circuit mode.
                        shift_field(mode, 3);
                        shift_field(it.service_info[6], 1);
                        shift_field(it.service_info[5:4], 2);
                        shift_field(mode == 3'd0 ? it.service_info[3:2]
                                                 : it.service_info[1:0], 2);
                        shift_field(it.grant, 2);
                        shift_field(trp, 1);
                        shift_field(it.priority_req, 4);
                        if (it.party_ssi != 24'd0)
                        begin
                            shift_field(1, 1);
                            shift_field(0, 2);
                            shift_field(1, 1);
                            shift_field(1, 2);
                            shift_field(it.party_ssi, 24);
                            shift_field(0, 1);
                        end
                        else
                        begin
                            shift_field(0, 1);
                        end
                    end
                    OP_TX_CEASED: begin
                        shift_field(9, 5);
                        shift_field(it.call_id, 14);
                        shift_field(trp, 1);
                        shift_field(0, 1);
                    end
                    default: begin
                        shift_field(11, 5);
                        shift_field(it.call_id, 14);
                        shift_field(it.grant, 2);
                        shift_field(trp, 1);
                        shift_field(it.flags[4], 1);
                        shift_field(it.flags[5], 1);
                        shift_field(0, 1);
                    end
                endcase
                close_body();
            end
        end
        foreach (step_beats[k])
            body_beats_due.push_back(step_beats[k]);
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic item_t random_request(input logic [3:0] op);
        logic [95:0] r;
        item_t it;
        r = {$urandom(), $urandom(), $urandom()};
        it = r[$bits(item_t)-1:0];
        it.opcode = op;
        return it;
    endfunction

    task automatic send_request(input item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= it.opcode;
        s_tdata <= {3'b000, it.data_byte, it.sds_length, it.party_ssi, it.cause,
                    it.priority_req, it.grant, it.service_info, it.flags,
                    it.time_out, it.call_id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pack_request(it);
    endtask

    // The sender stays quiet until every predicted byte has come out.
    task wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (body_beats_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 'h%0h, want 'h%0h at %0t ns", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            if (body_beats_due.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata, 0);
            end
            else
            begin
                want_beat = body_beats_due.pop_front();
                if (m_axis_tdata[7:0] !== want_beat.out_byte)
                    report_mismatch("out_byte", m_axis_tdata[7:0], want_beat.out_byte);
                if (m_axis_tdata[15:8] !== want_beat.bit_count)
                    report_mismatch("bit_count", m_axis_tdata[15:8], want_beat.bit_count);
                if (m_axis_tlast !== want_beat.last)
                    report_mismatch("last", m_axis_tlast, want_beat.last);
                if (m_axis_tuser !== want_beat.status)
                    report_mismatch("status", m_axis_tuser, want_beat.status);
            end
        end
    end

    // Ends a hung run: nothing accepted on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task test_pdu_extremes();
        item_t it;
        for (int op = OP_ALERT; op <= OP_TX_GRANT; op++)
        begin
            it = '1;
            it.opcode = op[3:0];
            send_request(it);
        end
        it = '0;
        it.opcode = OP_ALERT;
        send_request(it);
        it.opcode = OP_CONNECT;
        send_request(it);
        // Setup with no calling party element and speech service.
        it.opcode = OP_SETUP;
        send_request(it);
        it = '1;
        it.opcode = OP_SETUP;
        it.service_info = 10'h07F;
        send_request(it);
    endtask

    task test_sds_directed();
        item_t it;
        it = '1;
        it.opcode = OP_SDS_HDR;
        it.sds_length = 8'd1;
        send_request(it);
        it.opcode = OP_SDS_BYTE;
        send_request(it);
        it = random_request(OP_SDS_HDR);
        it.sds_length = 8'd0;
        send_request(it);
        it.sds_length = 8'(MAX_SDS_LEN + 1);
        send_request(it);
        // A user byte with no message open.
        send_request(random_request(OP_SDS_BYTE));
        wait_drained();
        // A call-control request cuts a pending message short.
        it = random_request(OP_SDS_HDR);
        it.sds_length = 8'd2;
        send_request(it);
        send_request(random_request(OP_SDS_BYTE));
        send_request(random_request(OP_RELEASE));
        send_request(random_request(OP_SDS_BYTE));
        send_request(random_request(OP_UNUSED_LO));
        send_request(random_request(OP_UNUSED_HI));
        wait_drained();
    endtask

    task test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
        item_t it;
        int    sent;
        int    pick;
        int    len;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                it = random_request(4'($urandom_range(OP_TX_GRANT, OP_ALERT)));
                if (it.opcode == OP_SETUP && $urandom_range(3) == 0)
                    it.party_ssi = '0;
                send_request(it);
                sent++;
            end
            else if (pick < 78)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(MAX_SDS_LEN, 7)
                                               : $urandom_range(4, 1);
                it = random_request(OP_SDS_HDR);
                it.sds_length = 8'(len);
                send_request(it);
                sent++;
                for (int k = 0; k < len; k++)
                begin
                    // Now and then the message is left unfinished.
                    if ($urandom_range(99) < 4)
                        break;
                    send_request(random_request(OP_SDS_BYTE));
                    sent++;
                end
            end
            else if (pick < 86)
            begin
                it = random_request(OP_SDS_HDR);
                it.sds_length = $urandom_range(1) ? 8'd0
                                                  : 8'($urandom_range(255, MAX_SDS_LEN + 1));
                send_request(it);
                sent++;
            end
            else if (pick < 93)
            begin
                send_request(random_request(OP_SDS_BYTE));
                sent++;
            end
            else
            begin
                send_request(random_request(4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO))));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        clear_packer();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_pdu_extremes();
        test_sds_directed();
        test_random_traffic(105, 0, 0);
        test_random_traffic(105, 74, 0);
        test_random_traffic(105, 0, 74);
        test_random_traffic(105, 20, 20);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: cmce_downlink_pdu_packer_unit.f
rtl/cdpp_pkg.sv
rtl/cdpp_packer.sv
rtl/cmce_downlink_pdu_packer_unit.sv
sim/cmce_downlink_pdu_packer_unit_tb.sv
